// File: hw/rtl/lcoc_pkg.sv
// ----------------------------------------------------------------------------
// lcoc_pkg
// Shared constants for the level crossing occupancy controller: field widths,
// action, way and mode codes, and parameter defaults.
// ----------------------------------------------------------------------------
package lcoc_pkg;

  // fixed field widths of the item ports
  localparam int VEH_ID_W = 8;
  localparam int ACT_W    = 2;
  localparam int WAY_W    = 2;
  localparam int MODE_W   = 2;

  // parameter defaults
  localparam int MAX_VEHICLES_DEF = 16;
  localparam int ID_BITS_DEF      = 8;

  // action codes
  localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  // way codes
  localparam logic [WAY_W-1:0] WAY_FIRST  = 2'd0;
  localparam logic [WAY_W-1:0] WAY_SECOND = 2'd1;

  // crossing modes
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REQ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd2;

endpackage

// File: hw/rtl/level_crossing_occupancy_controller.sv
// ----------------------------------------------------------------------------
// level_crossing_occupancy_controller
// Crossing guard for two ways, the second with priority. Keeps the vehicle
// ids occupying each way in two RAMs, answers request / add / release events
// with a grant and the crossing mode.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in        in         in_valid / in_stall  action, vehicle_id, way, is_pedestrian
//   out       out        out_valid/ out_stall granted, crossing_mode_out,
//                                             mode_changed, close_sound, set_full
//   cfg       in         cfg_valid/ cfg_ready cfg_data (sound_enabled)
//
// An event that looks up a set scans its RAM one entry per cycle through the
// single read port, then goes to the execute state. Events that need no lookup
// go straight from idle to the execute state.
// Reset is synchronous; it empties both sets (valid masks), clears the pending
// closer and sets the mode to open. No clearing pass is needed.
// The result sits in an output register; if it is stalled, the next item's
// update waits until the previous result is taken.
// ----------------------------------------------------------------------------
module level_crossing_occupancy_controller
  import lcoc_pkg::*;
#(
  parameter int MAX_VEHICLES = MAX_VEHICLES_DEF,
  parameter int ID_BITS      = ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  // event input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACT_W-1:0]    action,
  input  logic [VEH_ID_W-1:0] vehicle_id,
  input  logic [WAY_W-1:0]    way,
  input  logic                is_pedestrian,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output logic                granted,
  output logic [MODE_W-1:0]   crossing_mode_out,
  output logic                mode_changed,
  output logic                close_sound,
  output logic                set_full
);

  localparam int IDX_W = $clog2(MAX_VEHICLES);
  localparam int CNT_W = $clog2(MAX_VEHICLES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t state;

  // configuration and crossing state
  logic                    sound_en;
  logic [MODE_W-1:0]       mode;
  logic [MAX_VEHICLES-1:0] first_valid;
  logic [MAX_VEHICLES-1:0] second_valid;
  logic                    pc_valid;
  logic [ID_BITS-1:0]      pc_id;

  // captured item
  logic [ACT_W-1:0]   act_q;
  logic [ID_BITS-1:0] id_q;
  logic [WAY_W-1:0]   way_q;
  logic               ped_q;
  logic               scan_second;

  // scan bookkeeping
  logic [CNT_W-1:0] rd_cnt;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic               in_xfer;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] rd_first;
  logic [ID_BITS-1:0] rd_second;
  logic [ID_BITS-1:0] rd_sel;
  logic               chk_slot_valid;
  logic               chk_hit;
  logic               chk_last;
  logic               needs_scan;
  logic               scan_second_in;
  logic [ID_BITS-1:0] id_in;
  logic               out_free;

  // update computed in the execute cycle
  logic [MODE_W-1:0]       mode_next;
  logic [MAX_VEHICLES-1:0] first_valid_next;
  logic [MAX_VEHICLES-1:0] second_valid_next;
  logic                    pc_valid_next;
  logic [ID_BITS-1:0]      pc_id_next;
  logic                    granted_next;
  logic                    full_next;
  logic                    sound_next;
  logic                    wr_first;
  logic                    wr_second;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !(out_valid && out_stall);
  assign id_in     = ID_BITS'(vehicle_id);

  // which set an event has to look up, if any
  always_comb begin
    needs_scan     = 1'b0;
    scan_second_in = 1'b0;
    case (action)
      ACT_REQUEST: begin
        needs_scan = (way == WAY_FIRST);
      end
      ACT_ADD: begin
        needs_scan     = !is_pedestrian && (way == WAY_FIRST || way == WAY_SECOND);
        scan_second_in = (way == WAY_SECOND);
      end
      ACT_RELEASE: begin
        needs_scan     = 1'b1;
        scan_second_in = (way != WAY_FIRST);
      end
      default: begin
        needs_scan = 1'b0;
      end
    endcase
  end

  assign rd_en   = (state == S_SCAN) && (rd_cnt < CNT_W'(MAX_VEHICLES));
  assign rd_addr = rd_cnt[IDX_W-1:0];

  lcoc_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (MAX_VEHICLES)
  ) u_first_ram (
    .clk     (clk),
    .wr_en   (wr_first),
    .wr_addr (free_idx),
    .wr_data (id_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_first)
  );

  lcoc_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (MAX_VEHICLES)
  ) u_second_ram (
    .clk     (clk),
    .wr_en   (wr_second),
    .wr_addr (free_idx),
    .wr_data (id_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_second)
  );

  assign rd_sel         = scan_second ? rd_second : rd_first;
  assign chk_slot_valid = scan_second ? second_valid[chk_idx] : first_valid[chk_idx];
  assign chk_hit        = chk_vld && chk_slot_valid && (rd_sel == id_q);
  assign chk_last       = chk_vld && (chk_idx == IDX_W'(MAX_VEHICLES - 1));

  // event decision, applied at the end of the execute cycle
  always_comb begin
    mode_next         = mode;
    first_valid_next  = first_valid;
    second_valid_next = second_valid;
    pc_valid_next     = pc_valid;
    pc_id_next        = pc_id;
    granted_next      = 1'b0;
    full_next         = 1'b0;
    sound_next        = 1'b0;
    wr_first          = 1'b0;
    wr_second         = 1'b0;
    if (state == S_EXEC && out_free) begin
      case (act_q)
        ACT_REQUEST: begin
          if (way_q == WAY_FIRST) begin
            granted_next = ((second_valid == '0) && (mode == MODE_OPEN)) || found;
          end else if (way_q == WAY_SECOND) begin
            if (first_valid != '0) begin
              mode_next = MODE_REQ;
            end else begin
              pc_id_next    = id_q;
              pc_valid_next = 1'b1;
              mode_next     = MODE_CLOSED;
              sound_next    = sound_en;
              granted_next  = 1'b1;
            end
          end else begin
            granted_next = 1'b1;
          end
        end
        ACT_ADD: begin
          if (!ped_q && way_q == WAY_FIRST) begin
            if (!found) begin
              if (free_found) begin
                wr_first                   = 1'b1;
                first_valid_next[free_idx] = 1'b1;
              end else begin
                full_next = 1'b1;
              end
            end
          end else if (!ped_q && way_q == WAY_SECOND) begin
            if (!found) begin
              if (free_found) begin
                wr_second                   = 1'b1;
                second_valid_next[free_idx] = 1'b1;
              end else begin
                full_next = 1'b1;
              end
            end
            if (pc_valid && pc_id == id_q) begin
              pc_valid_next = 1'b0;
            end
            // closed is commanded even when the add was dropped
            mode_next  = MODE_CLOSED;
            sound_next = sound_en;
          end
        end
        ACT_RELEASE: begin
          if (way_q == WAY_FIRST) begin
            if (found) begin
              first_valid_next[found_idx] = 1'b0;
            end
            if (mode == MODE_REQ && first_valid_next == '0) begin
              mode_next  = MODE_CLOSED;
              sound_next = sound_en;
            end
          end else begin
            if (found) begin
              second_valid_next[found_idx] = 1'b0;
            end
            if (pc_valid && pc_id == id_q) begin
              pc_valid_next = 1'b0;
            end
            if (second_valid_next == '0 && !pc_valid_next) begin
              mode_next = MODE_OPEN;
            end
          end
        end
        default: begin
          granted_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sound_en     <= 1'b1;
      mode         <= MODE_OPEN;
      first_valid  <= '0;
      second_valid <= '0;
      pc_valid     <= 1'b0;
      rd_cnt       <= '0;
      chk_vld      <= 1'b0;
      found        <= 1'b0;
      free_found   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sound_en <= cfg_data;
      end
      // a new result loads in the same cycle the old one is taken
      if (state == S_EXEC && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            act_q       <= action;
            id_q        <= id_in;
            way_q       <= way;
            ped_q       <= is_pedestrian;
            scan_second <= scan_second_in;
            rd_cnt      <= '0;
            chk_vld     <= 1'b0;
            found       <= 1'b0;
            free_found  <= 1'b0;
            state       <= needs_scan ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          chk_vld <= rd_en;
          chk_idx <= rd_addr;
          if (chk_hit && !found) begin
            found     <= 1'b1;
            found_idx <= chk_idx;
          end
          // first empty slot, for an insert
          if (chk_vld && !chk_slot_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          if (chk_last) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            mode              <= mode_next;
            first_valid       <= first_valid_next;
            second_valid      <= second_valid_next;
            pc_valid          <= pc_valid_next;
            pc_id             <= pc_id_next;
            granted           <= granted_next;
            crossing_mode_out <= mode_next;
            mode_changed      <= (mode_next != mode);
            close_sound       <= sound_next;
            set_full          <= full_next;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lcoc_ram.sv
// ----------------------------------------------------------------------------
// lcoc_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module lcoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/lcoc_checker.sv
// ----------------------------------------------------------------------------
// lcoc_checker
// Port-level checks for the level crossing occupancy controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module lcoc_checker
  import lcoc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              granted,
  input logic [MODE_W-1:0] crossing_mode_out,
  input logic              close_sound,
  input logic              set_full
);

  // a result offered and not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one event in flight: the input stalls right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second event taken while one is in flight");

  // the close sound only comes with the crossing closed
  a_sound_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && close_sound |-> crossing_mode_out == MODE_CLOSED)
    else $error("close sound without closed mode");

  // a dropped add never grants passage
  a_full_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && set_full |-> !granted)
    else $error("set full together with a grant");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind level_crossing_occupancy_controller lcoc_checker u_lcoc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .granted           (granted),
  .crossing_mode_out (crossing_mode_out),
  .close_sound       (close_sound),
  .set_full          (set_full)
);
